// File: sv/dse_pkg.sv
// ----------------------------------------------------------------------------
// dse_pkg
// Types and register codes shared by the seed extractor modules.
// ----------------------------------------------------------------------------
package dse_pkg;

  // One base of a read.
  typedef struct packed {
    logic [3:0]  base_code4;
    logic [1:0]  base_code2;
    logic        first_base;
    logic [15:0] read_length;
  } in_item_t;

  // One extracted seed.
  typedef struct packed {
    logic [15:0] seed_offset;
    logic [63:0] seed_forward;
    logic [63:0] seed_revcomp;
    logic        seed_valid;
  } out_item_t;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_SEED_LENGTH    = 2'd0,
    REG_PATTERN_PERIOD = 2'd1,
    REG_OFFSET_PATTERN = 2'd2,
    REG_FORCED_TAIL    = 2'd3
  } reg_idx_t;

  localparam logic [5:0]  SEED_LENGTH_RST    = 6'd21;
  localparam logic [5:0]  PATTERN_PERIOD_RST = 6'd1;
  localparam logic [31:0] OFFSET_PATTERN_RST = 32'd1;
  localparam logic [7:0]  FORCED_TAIL_RST    = 8'd0;

  localparam logic [3:0] CODE_GAP = 4'h0;
  localparam logic [3:0] CODE_N   = 4'hf;
  localparam logic [1:0] PAIR_MASK = 2'b11;

  // Control handed to every cell of the window chain.
  typedef struct packed {
    logic shift;
    logic flush_fwd;
    logic flush_rc;
  } cell_ctrl_t;

endpackage

// File: sv/dse_cell.sv
// ----------------------------------------------------------------------------
// dse_cell
// One base slot of the window: forward pair, complemented pair, clean flag.
// ----------------------------------------------------------------------------
module dse_cell
  import dse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic [1:0] fwd_in,
  input  logic       clean_in,
  input  logic [1:0] rc_in,
  output logic [1:0] fwd_q,
  output logic       clean_q,
  output logic [1:0] rc_q,
  output logic [1:0] fwd_nxt,
  output logic       clean_nxt,
  output logic [1:0] rc_nxt
);

  logic [1:0] fwd_r;
  logic       clean_r;
  logic [1:0] rc_r;

  // A new read flushes what the neighbour hands over, except at the entry slot.
  always_comb begin
    fwd_nxt   = fwd_r;
    clean_nxt = clean_r;
    rc_nxt    = rc_r;
    if (ctrl.shift) begin
      fwd_nxt   = ctrl.flush_fwd ? 2'b00 : fwd_in;
      clean_nxt = ctrl.flush_fwd ? 1'b0  : clean_in;
      rc_nxt    = ctrl.flush_rc  ? 2'b00 : rc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r   <= 2'b00;
      clean_r <= 1'b0;
      rc_r    <= 2'b00;
    end else begin
      fwd_r   <= fwd_nxt;
      clean_r <= clean_nxt;
      rc_r    <= rc_nxt;
    end
  end

  assign fwd_q   = fwd_r;
  assign clean_q = clean_r;
  assign rc_q    = rc_r;

endmodule

// File: sv/dse_cfg_regs.sv
// ----------------------------------------------------------------------------
// dse_cfg_regs
// APB register file holding the seeding configuration.
// ----------------------------------------------------------------------------
module dse_cfg_regs
  import dse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [5:0]  seed_length,
  output logic [5:0]  pattern_period,
  output logic [31:0] offset_pattern,
  output logic [7:0]  forced_tail
);

  logic [5:0]  seed_length_r;
  logic [5:0]  pattern_period_r;
  logic [31:0] offset_pattern_r;
  logic [7:0]  forced_tail_r;
  reg_idx_t    idx;
  logic        wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_length_r    <= SEED_LENGTH_RST;
      pattern_period_r <= PATTERN_PERIOD_RST;
      offset_pattern_r <= OFFSET_PATTERN_RST;
      forced_tail_r    <= FORCED_TAIL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEED_LENGTH:    seed_length_r    <= pwdata[5:0];
        REG_PATTERN_PERIOD: pattern_period_r <= pwdata[5:0];
        REG_OFFSET_PATTERN: offset_pattern_r <= pwdata;
        REG_FORCED_TAIL:    forced_tail_r    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEED_LENGTH:    prdata = {26'd0, seed_length_r};
      REG_PATTERN_PERIOD: prdata = {26'd0, pattern_period_r};
      REG_OFFSET_PATTERN: prdata = offset_pattern_r;
      REG_FORCED_TAIL:    prdata = {24'd0, forced_tail_r};
      default:            prdata = 32'd0;
    endcase
  end

  assign seed_length    = seed_length_r;
  assign pattern_period = pattern_period_r;
  assign offset_pattern = offset_pattern_r;
  assign forced_tail    = forced_tail_r;

endmodule

// File: sv/dna_seed_extractor.sv
// ----------------------------------------------------------------------------
// dna_seed_extractor
// Streaming k-mer seed extraction with reverse complement.
// ----------------------------------------------------------------------------
// Bases of a read enter one item per cycle, while the receiver keeps up, on
// the in_ channel; a base with first_base set starts a new read at position
// zero. The window is a chain of cells, one per base, shifting forward and
// complemented codes in opposite directions on every accepted base that is
// in range or starts a read. Each accepted base yields zero or one seed item
// on the out_ channel in the cycle after acceptance, via the output register.
// With the receiver ready, throughput is one base per cycle: the window
// shift, sampling and tail checks all settle in the cycle of acceptance.
// Bases at or past read_length are taken and dropped; such a base has an
// effect only on a new read, where it clears window, position and phase.
// When the receiver stalls, the pending seed is held in the output register
// and a new base is taken only in a cycle in which that seed leaves.
// Reset empties the window, clears the position and sampling phase and loads
// the default configuration; no clearing pass is needed.
// Configuration is written through the APB port, registers at byte offsets
// 0, 4, 8 and 12, and should only change while the block is idle.
// ----------------------------------------------------------------------------
module dna_seed_extractor
  import dse_pkg::*;
#(
  parameter int MAX_SEED_BASES = 32,
  parameter int POSITION_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;
  localparam int WW = 2 * MAX_SEED_BASES;

  logic [5:0]  seed_length;
  logic [5:0]  pattern_period;
  logic [31:0] offset_pattern;
  logic [7:0]  forced_tail;

  dse_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .seed_length    (seed_length),
    .pattern_period (pattern_period),
    .offset_pattern (offset_pattern),
    .forced_tail    (forced_tail)
  );

  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_eff;
  logic [4:0]               phase_r, phase_nxt, phase_eff, phase_sel;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic       in_fire, in_range, reached, emit, base_clean;
  logic [5:0] len, period, phase_inc;
  logic [CW-1:0] pos_p1, tail_sum;
  logic [6:0]    shamt;
  cell_ctrl_t    ctrl_base;

  logic [MAX_SEED_BASES-1:0][1:0] fwd_q, fwd_nxt, rc_q, rc_nxt, rc_mask;
  logic [MAX_SEED_BASES-1:0]      clean_q, clean_nxt;
  logic [WW-1:0]                  fwd_shifted;
  logic                           window_clean;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign base_clean = (in_data.base_code4 != CODE_GAP) && (in_data.base_code4 != CODE_N);

  always_comb begin
    if (seed_length == 6'd0) begin
      len = 6'd1;
    end else if (seed_length > 6'(MAX_SEED_BASES)) begin
      len = 6'(MAX_SEED_BASES);
    end else begin
      len = seed_length;
    end
    if (pattern_period == 6'd0) begin
      period = 6'd1;
    end else if (pattern_period > 6'd32) begin
      period = 6'd32;
    end else begin
      period = pattern_period;
    end
  end

  assign pos_eff   = in_data.first_base ? '0 : pos_r;
  assign phase_eff = in_data.first_base ? 5'd0 : phase_r;
  assign pos_p1    = CW'(pos_eff) + CW'(1);
  assign in_range  = CW'(pos_eff) < CW'(in_data.read_length);
  assign reached   = pos_p1 >= CW'(len);
  assign tail_sum  = pos_p1 + CW'(forced_tail);

  // A phase left beyond a lowered period counts as zero.
  assign phase_sel = (6'(phase_eff) < period) ? phase_eff : 5'd0;
  assign phase_inc = 6'(phase_sel) + 6'd1;

  assign emit = in_fire && in_range && reached &&
                (offset_pattern[phase_sel] || (tail_sum > CW'(in_data.read_length)));

  // A new read empties the window even when its first base is dropped.
  assign ctrl_base.shift     = in_fire && (in_range || in_data.first_base);
  assign ctrl_base.flush_fwd = in_data.first_base;
  assign ctrl_base.flush_rc  = in_data.first_base;

  // Forward codes enter at the top cell, complemented codes at the bottom.
  for (genvar i = 0; i < MAX_SEED_BASES; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [1:0] fwd_in, rc_in;
    logic       clean_in;

    assign ctrl.shift = ctrl_base.shift;
    if (i == MAX_SEED_BASES - 1) begin : g_fwd_head
      assign fwd_in         = in_data.base_code2;
      assign clean_in       = base_clean;
      assign ctrl.flush_fwd = in_data.first_base && !in_range;
    end else begin : g_fwd_link
      assign fwd_in         = fwd_q[i+1];
      assign clean_in       = clean_q[i+1];
      assign ctrl.flush_fwd = ctrl_base.flush_fwd;
    end
    if (i == 0) begin : g_rc_head
      assign rc_in         = ~in_data.base_code2 & PAIR_MASK;
      assign ctrl.flush_rc = in_data.first_base && !in_range;
    end else begin : g_rc_link
      assign rc_in         = rc_q[i-1];
      assign ctrl.flush_rc = ctrl_base.flush_rc;
    end

    dse_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .fwd_in    (fwd_in),
      .clean_in  (clean_in),
      .rc_in     (rc_in),
      .fwd_q     (fwd_q[i]),
      .clean_q   (clean_q[i]),
      .rc_q      (rc_q[i]),
      .fwd_nxt   (fwd_nxt[i]),
      .clean_nxt (clean_nxt[i]),
      .rc_nxt    (rc_nxt[i])
    );
  end

  // The seed is the newest len cells of each chain.
  assign shamt       = 7'(WW) - {len, 1'b0};
  assign fwd_shifted = fwd_nxt >> shamt;

  always_comb begin
    window_clean = 1'b1;
    for (int i = 0; i < MAX_SEED_BASES; i++) begin
      rc_mask[i] = (7'(i) < 7'(len)) ? PAIR_MASK : 2'b00;
      if ((7'(i) + 7'(len)) >= 7'(MAX_SEED_BASES)) begin
        window_clean = window_clean & clean_nxt[i];
      end
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      if (in_range) begin
        pos_nxt = pos_p1[POSITION_BITS-1:0];
        if (reached) begin
          phase_nxt = (phase_inc >= period) ? 5'd0 : phase_inc[4:0];
        end else begin
          phase_nxt = phase_eff;
        end
      end else if (in_data.first_base) begin
        pos_nxt   = '0;
        phase_nxt = 5'd0;
      end
      out_valid_nxt = emit;
      if (emit) begin
        out_data_nxt.seed_offset  = 16'(pos_p1 - CW'(len));
        out_data_nxt.seed_forward = 64'(fwd_shifted);
        out_data_nxt.seed_revcomp = 64'(rc_nxt & rc_mask);
        out_data_nxt.seed_valid   = window_clean;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/dse_checker.sv
// ----------------------------------------------------------------------------
// dse_checker
// Port-level checks on the seed extractor, bound to the top level.
// ----------------------------------------------------------------------------
module dse_checker
  import dse_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled seed stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("seed item changed while stalled");

  // The output register frees the input side whenever it empties.
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output register");

  // A seed only appears because a base was accepted.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) && !(in_valid && in_ready) |=> !out_valid)
    else $error("seed item appeared without an accepted base");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output not empty after reset");

endmodule

bind dna_seed_extractor dse_checker u_dse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
